// File: design/wsfd_pkg.sv
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and constants shared by the weather sensor frame decoder.
// ----------------------------------------------------------------------------
package wsfd_pkg;

  localparam int unsigned FrameLen = 12;
  localparam int unsigned SumBytes = 10;

  localparam logic [7:0] SepByte    = 8'hFF;
  localparam logic [7:0] IdTempHum  = 8'h42;
  localparam logic [7:0] IdDateTime = 8'h60;

  localparam logic CmdData   = 1'b0;
  localparam logic CmdResync = 1'b1;

  localparam logic [1:0] StatusTempHum  = 2'd0;
  localparam logic [1:0] StatusDateTime = 2'd1;
  localparam logic [1:0] StatusCsumErr  = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [3:0]         channel;
    logic signed [15:0] temperature_tenths;
    logic [7:0]         humidity;
  } result_t;

endpackage

// File: design/wsfd_out_buf.sv
// ----------------------------------------------------------------------------
// wsfd_out_buf
// Two-slot result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module wsfd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsfd_pkg::result_t push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsfd_pkg::result_t out_data_o
);
  import wsfd_pkg::*;

  result_t main_q, skid_q;
  logic    main_vld_q, skid_vld_q;
  logic    pop;

  assign pop         = main_vld_q && !out_stall_i;
  assign full_o      = skid_vld_q;
  assign out_valid_o = main_vld_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_vld_q <= 1'b1;
        skid_vld_q <= push_i;
      end else begin
        main_vld_q <= push_i;
      end
    end else if (push_i) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_vld_q || pop) begin
      if (skid_vld_q) begin
        main_q <= skid_q;
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

endmodule

// File: design/weather_sensor_frame_decoder.sv
// ----------------------------------------------------------------------------
// weather_sensor_frame_decoder
// Byte-wise weather-station frame decoder with checksum verification.
// ----------------------------------------------------------------------------
// Takes one payload byte or resync command per cycle. The result of a
// completed 12-byte frame is pushed into the output buffer as its last byte
// is taken. Frame bytes 0..11 live in flip-flops, the checksum is a running
// 16-bit sum of bytes 0..9, updated as they are written. A two-slot output
// buffer holds results; the input stalls while both slots are occupied.
module weather_sensor_frame_decoder #(
  parameter int unsigned MSG_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  logic [7:0]        data_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [3:0]        channel_o,
  output logic signed [15:0] temperature_tenths_o,
  output logic [7:0]        humidity_o
);
  import wsfd_pkg::*;

  localparam int unsigned PosW = $clog2(MSG_BYTES);

  logic [7:0]      byte_q [FrameLen];
  logic [7:0]      last_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     sum_q, sum_d;

  logic            accept, is_data, buf_full, push;
  logic [7:0]      prev_byte, old_byte;
  logic [PosW:0]   pos_inc;
  logic [15:0]     want;
  logic [14:0]     mag;
  logic [15:0]     temp;
  logic            id_ok;
  result_t         res;
  result_t         out_data;

  assign accept  = in_valid_i && !in_stall_o;
  assign is_data = (command_i == CmdData);
  assign in_stall_o = buf_full;

  assign prev_byte = (pos_q == PosW'(2)) ? byte_q[1] : last_q;
  assign old_byte  = byte_q[pos_q[3:0]];
  assign pos_inc   = {1'b0, pos_q} + (PosW+1)'(1);

  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    if (!is_data) begin
      sum_d = sum_q - {8'd0, byte_q[0]} - {8'd0, byte_q[1]};
      pos_d = PosW'(2);
    end else begin
      if (pos_q < PosW'(SumBytes)) begin
        sum_d = sum_q - {8'd0, old_byte} + {8'd0, data_byte_i};
      end
      if (pos_q != '0 && prev_byte == SepByte && data_byte_i == SepByte) begin
        pos_d = '0;
      end else if (pos_inc >= (PosW+1)'(MSG_BYTES)) begin
        pos_d = PosW'(2);
      end else begin
        pos_d = pos_inc[PosW-1:0];
      end
    end
  end

  assign want  = {data_byte_i, byte_q[10]};
  assign mag   = {byte_q[4][6:0], byte_q[3]};
  assign temp  = byte_q[4][7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
  assign id_ok = (byte_q[1] == IdTempHum) || (byte_q[1] == IdDateTime);
  assign push  = accept && is_data && (pos_q == PosW'(FrameLen - 1)) && id_ok;

  always_comb begin
    res.status             = StatusCsumErr;
    res.channel            = 4'd0;
    res.temperature_tenths = 16'sd0;
    res.humidity           = 8'd0;
    if (sum_q == want) begin
      if (byte_q[1] == IdDateTime) begin
        res.status = StatusDateTime;
      end else begin
        res.status             = StatusTempHum;
        res.channel            = byte_q[2][3:0];
        res.temperature_tenths = temp;
        res.humidity           = byte_q[5];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosW'(2);
      sum_q <= '0;
      for (int i = 0; i < FrameLen; i++) begin
        byte_q[i] <= '0;
      end
    end else if (accept) begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      if (!is_data) begin
        byte_q[0] <= '0;
        byte_q[1] <= '0;
      end else if (pos_q < PosW'(FrameLen)) begin
        byte_q[pos_q[3:0]] <= data_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_data) begin
      last_q <= data_byte_i;
    end
  end

  wsfd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign status_o             = out_data.status;
  assign channel_o            = out_data.channel;
  assign temperature_tenths_o = out_data.temperature_tenths;
  assign humidity_o           = out_data.humidity;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, pos_q} < (PosW+1)'(MSG_BYTES)))
    else $error("byte position out of range");

  a_resync_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i == CmdResync) |=> (pos_q == PosW'(2) && byte_q[1] == 8'd0))
    else $error("resync did not restart position");

  a_sep_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_data && pos_q != '0 && prev_byte == SepByte && data_byte_i == SepByte)
    |=> (pos_q == '0))
    else $error("separator did not restart message");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(push))
    else $error("result without a completed frame");

  a_temp_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatusTempHum) |-> (temperature_tenths_o == 16'sd0
      && channel_o == 4'd0 && humidity_o == 8'd0))
    else $error("non-measurement result carries data");

endmodule

// File: test/weather_sensor_frame_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weather_sensor_frame_decoder_tb
// Self-checking testbench for the weather sensor frame decoder.
// ----------------------------------------------------------------------------
// Streams payload bytes and resync commands into the decoder and predicts each
// frame result from a local copy of the message store, byte position and
// running checksum. Directed tasks cover the temperature and humidity
// extremes, both identifiers, unknown identifiers, resync, position wrap and a
// separator pair that lands in the checksum bytes. A random stream of mostly
// well-formed frames with noise, truncated frames and long runs follows. Both
// sides idle at random, and one stretch holds the output off long enough to
// fill the decoder and stall its input.
module weather_sensor_frame_decoder_tb;
  import wsfd_pkg::*;

  localparam int unsigned MsgBytes = 32;

  typedef logic [7:0] frame_t [FrameLen];

  logic        clk_i                = 1'b0;
  logic        rst_ni               = 1'b0;
  logic        in_valid_i           = 1'b0;
  logic        command_i            = CmdData;
  logic [7:0]  data_byte_i          = 8'h00;
  logic        out_stall_i          = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [3:0]  channel_o;
  logic signed [15:0] temperature_tenths_o;
  logic [7:0]  humidity_o;

  logic [7:0]  msg_bytes [MsgBytes];
  int          next_pos;
  logic [15:0] byte_sum;

  result_t     expected_results [$];
  int          mismatches       = 0;
  int          bytes_sent       = 0;
  bit          tx_idle          = 1'b1;
  bit          rx_idle          = 1'b1;
  int          hold_cycles_req  = 0;

  weather_sensor_frame_decoder #(
    .MSG_BYTES(MsgBytes)
  ) i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .command_i           (command_i),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .status_o            (status_o),
    .channel_o           (channel_o),
    .temperature_tenths_o(temperature_tenths_o),
    .humidity_o          (humidity_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("weather_sensor_frame_decoder_tb: done, errors");
    $finish;
  end

  function automatic void store_msg_byte(input int pos, input logic [7:0] b);
    if (pos < SumBytes) begin
      byte_sum = byte_sum - 16'(msg_bytes[pos]) + 16'(b);
    end
    msg_bytes[pos] = b;
  endfunction

  function automatic void decode_byte(input logic cmd, input logic [7:0] b,
                                      output bit has_result, output result_t res);
    int          p;
    logic [15:0] want_sum;
    logic [15:0] mag;
    has_result = 1'b0;
    res        = '0;
    if (cmd == CmdResync) begin
      store_msg_byte(0, 8'h00);
      store_msg_byte(1, 8'h00);
      next_pos = 2;
      return;
    end
    p = next_pos;
    if (p >= MsgBytes) p = 2;
    store_msg_byte(p, b);
    if (p + 1 == FrameLen && (msg_bytes[1] == IdTempHum || msg_bytes[1] == IdDateTime)) begin
      has_result = 1'b1;
      want_sum   = {msg_bytes[11], msg_bytes[10]};
      res.status = StatusCsumErr;
      if (byte_sum == want_sum) begin
        if (msg_bytes[1] == IdDateTime) begin
          res.status = StatusDateTime;
        end else begin
          mag                    = {1'b0, msg_bytes[4][6:0], msg_bytes[3]};
          res.status             = StatusTempHum;
          res.channel            = msg_bytes[2][3:0];
          res.temperature_tenths = msg_bytes[4][7] ? 16'd0 - mag : mag;
          res.humidity           = msg_bytes[5];
        end
      end
    end
    if (p > 0 && msg_bytes[p-1] == SepByte && b == SepByte) p = 0;
    else p++;
    if (p >= MsgBytes) p = 2;
    next_pos = p;
  endfunction

  function automatic frame_t make_frame(input logic [7:0] id, input logic [7:0] ch,
                                        input logic [7:0] t_lo, input logic [7:0] t_hi,
                                        input logic [7:0] hum, input bit good_sum);
    frame_t      f;
    logic [15:0] s;
    f[0] = 8'($urandom_range(0, 254));
    f[1] = id;
    f[2] = ch;
    f[3] = t_lo;
    f[4] = t_hi;
    f[5] = hum;
    for (int i = 6; i < SumBytes; i++) f[i] = 8'($urandom_range(0, 255));
    s = '0;
    for (int i = 0; i < SumBytes; i++) s = s + 16'(f[i]);
    if (!good_sum) s = s + 16'($urandom_range(1, 500));
    f[10] = s[7:0];
    f[11] = s[15:8];
    return f;
  endfunction

  task automatic send_transfer(input logic cmd, input logic [7:0] b);
    int      gap;
    bit      has_result;
    result_t res;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    data_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(cmd, b, has_result, res);
    if (has_result) expected_results.push_back(res);
    bytes_sent++;
  endtask

  task automatic send_sync();
    send_transfer(CmdData, SepByte);
    send_transfer(CmdData, SepByte);
  endtask

  task automatic send_frame(input frame_t f, input int first, input int last);
    for (int i = first; i <= last; i++) send_transfer(CmdData, f[i]);
  endtask

  task automatic send_random_frame();
    logic [7:0] id;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) id = IdTempHum;
    else if (pick < 90) id = IdDateTime;
    else id = 8'($urandom_range(0, 255));
    send_sync();
    send_frame(make_frame(id, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          $urandom_range(0, 9) != 0), 0, FrameLen - 1);
  endtask

  task automatic test_temp_hum_extremes();
    send_sync();
    send_frame(make_frame(IdTempHum, 8'hF3, 8'hFF, 8'h7F, 8'hFF, 1'b1), 0, FrameLen - 1);
    send_sync();
    send_frame(make_frame(IdTempHum, 8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1), 0, FrameLen - 1);
    send_sync();
    send_frame(make_frame(IdTempHum, 8'h0A, 8'h00, 8'h80, 8'h37, 1'b1), 0, FrameLen - 1);
  endtask

  task automatic test_status_frames();
    send_sync();
    send_frame(make_frame(IdDateTime, 8'h15, 8'h22, 8'h33, 8'h44, 1'b1), 0, FrameLen - 1);
    send_sync();
    send_frame(make_frame(IdDateTime, 8'h15, 8'h22, 8'h33, 8'h44, 1'b0), 0, FrameLen - 1);
    send_sync();
    send_frame(make_frame(IdTempHum, 8'h01, 8'h10, 8'h02, 8'h50, 1'b0), 0, FrameLen - 1);
    send_sync();
    send_frame(make_frame(8'h13, 8'h01, 8'h10, 8'h02, 8'h50, 1'b1), 0, FrameLen - 1);
  endtask

  task automatic test_sep_in_checksum();
    frame_t f;
    f     = make_frame(IdTempHum, 8'h02, 8'h05, 8'h01, 8'h20, 1'b1);
    f[10] = SepByte;
    f[11] = SepByte;
    send_sync();
    send_frame(f, 0, FrameLen - 1);
    send_frame(make_frame(IdTempHum, 8'h03, 8'h06, 8'h81, 8'h21, 1'b1), 0, FrameLen - 1);
  endtask

  task automatic test_resync();
    send_transfer(CmdResync, 8'hA5);
    send_frame(make_frame(IdTempHum, 8'h04, 8'h07, 8'h00, 8'h22, 1'b1), 2, FrameLen - 1);
    send_sync();
    send_frame(make_frame(IdTempHum, 8'h05, 8'h08, 8'h00, 8'h23, 1'b1), 0, FrameLen - 1);
  endtask

  task automatic test_position_wrap();
    frame_t f;
    f = make_frame(IdTempHum, 8'h06, 8'h09, 8'h00, 8'h24, 1'b1);
    send_sync();
    send_frame(f, 0, 1);
    for (int i = 2; i < MsgBytes; i++) send_transfer(CmdData, 8'($urandom_range(0, 254)));
    send_frame(f, 2, FrameLen - 1);
  endtask

  task automatic test_back_pressure();
    tx_idle         = 1'b0;
    hold_cycles_req = 300;
    repeat (10) send_random_frame();
    tx_idle         = 1'b1;
  endtask

  task automatic test_random_stream();
    int target;
    int kind;
    target = bytes_sent + 270;
    while (bytes_sent < target) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      kind    = $urandom_range(0, 99);
      if (kind < 70) begin
        send_random_frame();
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 16)) send_transfer(CmdData, 8'($urandom));
      end else if (kind < 85) begin
        send_transfer(CmdResync, 8'($urandom));
      end else if (kind < 93) begin
        send_sync();
        send_frame(make_frame(IdTempHum, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'b1), 0, $urandom_range(0, FrameLen - 2));
      end else begin
        repeat ($urandom_range(20, 40)) send_transfer(CmdData, 8'($urandom_range(0, 254)));
      end
    end
  endtask

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles_req > 0) begin
        n               = hold_cycles_req;
        hold_cycles_req = 0;
      end else begin
        n = rx_idle ? $urandom_range(0, 5) : 0;
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o && hold_cycles_req == 0);
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{status_o, channel_o, temperature_tenths_o, humidity_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected transfer: status %0d channel %0d temp %0d humidity %0d",
                 $time, got.status, got.channel, got.temperature_tenths, got.humidity);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch: expected status %0d channel %0d temp %0d humidity %0d",
                   $time, want.status, want.channel, want.temperature_tenths, want.humidity);
          $display("%0t:           actual   status %0d channel %0d temp %0d humidity %0d",
                   $time, got.status, got.channel, got.temperature_tenths, got.humidity);
          mismatches++;
        end
      end
    end
  end

  initial begin
    foreach (msg_bytes[i]) msg_bytes[i] = 8'h00;
    next_pos = 2;
    byte_sum = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_temp_hum_extremes();
    test_status_frames();
    test_sep_in_checksum();
    test_resync();
    test_position_wrap();
    test_back_pressure();
    test_random_stream();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("weather_sensor_frame_decoder_tb: done, clean");
    end else begin
      $display("weather_sensor_frame_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
